/* src/chtab_pkg.sv */
// chtab_pkg: shared types, constants and codes of the chained hash table
// used by every module of the block but chtab_ram; depends on nothing
`default_nettype none
package chtab_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int PTR_W    = IDX_W + 1;
  localparam int TS_W     = 9;
  localparam int DATA_W   = 32;
  localparam int Q_DEPTH  = 2;
  localparam int QPTR_W   = $clog2(Q_DEPTH);

  localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

  localparam logic [DATA_W-1:0] FMIX_C1 = 32'h85eb_ca6b;
  localparam logic [DATA_W-1:0] FMIX_C2 = 32'hc2b2_ae35;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_FIND   = 2'd0;
  localparam opcode_t OP_ADD    = 2'd1;
  localparam opcode_t OP_DELETE = 2'd2;
  localparam opcode_t OP_CLEAR  = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_ABSENT = 2'd2;

  localparam logic CFG_TABLE_SIZE = 1'b0;
  localparam logic CFG_NOT_FOUND  = 1'b1;

  typedef struct packed {
    opcode_t            op;
    logic [DATA_W-1:0]  key;
    logic [DATA_W-1:0]  value;
    logic [IDX_W-1:0]   bucket;
  } req_t;

endpackage
`default_nettype wire

/* src/chtab_ram.sv */
// chtab_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module chtab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* src/chtab_fifo.sv */
// chtab_fifo: short request queue between the hashing front and the table back
// depends on chtab_pkg
`default_nettype none
module chtab_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire chtab_pkg::req_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output chtab_pkg::req_t     head
);
  import chtab_pkg::*;

  req_t              ent_r [Q_DEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == (QPTR_W+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = ent_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      ent_r[wp_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* src/chtab_front.sv */
// chtab_front: takes requests, runs the fmix32 hash and the bucket modulo
// depends on chtab_pkg; feeds chtab_fifo
`default_nettype none
module chtab_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire chtab_pkg::opcode_t         in_opcode,
  input  wire logic [chtab_pkg::DATA_W-1:0] in_key,
  input  wire logic [chtab_pkg::DATA_W-1:0] in_value,
  input  wire logic [chtab_pkg::PTR_W-1:0]  table_size,
  output logic                            push,
  output chtab_pkg::req_t                 push_data,
  input  wire logic                       q_full
);
  import chtab_pkg::*;

  localparam int DIV_ITER = DATA_W / 2;
  localparam int CNT_W    = $clog2(DIV_ITER);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL1 = 3'd1;
  localparam logic [2:0] F_MUL2 = 3'd2;
  localparam logic [2:0] F_MIX  = 3'd3;
  localparam logic [2:0] F_DIV  = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;

  logic [2:0]        fst_r, fst_nxt;
  opcode_t           op_r, op_nxt;
  logic [DATA_W-1:0] key_r, key_nxt, val_r, val_nxt, h_r, h_nxt;
  logic [PTR_W-1:0]  rem_r, rem_nxt, rem_mid;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] mix13;

  // one restoring step of the remainder, remainder stays below the divisor
  function automatic logic [PTR_W-1:0] div_step(input logic [PTR_W-1:0] r,
                                                input logic b,
                                                input logic [PTR_W-1:0] d);
    logic [PTR_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[PTR_W-1:0];
  endfunction

  assign busy  = (fst_r != F_IDLE);
  assign mix13 = h_r ^ (h_r >> 13);
  assign rem_mid = div_step(rem_r, h_r[DATA_W-1], table_size);

  always_comb begin
    fst_nxt = fst_r;
    op_nxt  = op_r;
    key_nxt = key_r;
    val_nxt = val_r;
    h_nxt   = h_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    push    = 1'b0;
    unique case (fst_r)
      F_IDLE: begin
        if (start) begin
          op_nxt  = in_opcode;
          key_nxt = in_key;
          val_nxt = in_value;
          h_nxt   = in_key ^ (in_key >> 16);
          rem_nxt = '0;
          fst_nxt = (in_opcode == OP_CLEAR) ? F_PUSH : F_MUL1;
        end
      end
      F_MUL1: begin
        h_nxt   = h_r * FMIX_C1;
        fst_nxt = F_MUL2;
      end
      F_MUL2: begin
        h_nxt   = mix13 * FMIX_C2;
        fst_nxt = F_MIX;
      end
      F_MIX: begin
        h_nxt   = h_r ^ (h_r >> 16);
        rem_nxt = '0;
        cnt_nxt = '0;
        fst_nxt = F_DIV;
      end
      F_DIV: begin
        // two dividend bits per cycle, msb first
        rem_nxt = div_step(rem_mid, h_r[DATA_W-2], table_size);
        h_nxt   = h_r << 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_ITER - 1)) begin
          fst_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          push    = 1'b1;
          fst_nxt = F_IDLE;
        end
      end
      default: fst_nxt = F_IDLE;
    endcase
  end

  assign push_data.op     = op_r;
  assign push_data.key    = key_r;
  assign push_data.value  = val_r;
  assign push_data.bucket = rem_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r <= F_IDLE;
      cnt_r <= '0;
    end else begin
      fst_r <= fst_nxt;
      cnt_r <= cnt_nxt;
    end
    op_r  <= op_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
    h_r   <= h_nxt;
    rem_r <= rem_nxt;
  end

endmodule
`default_nettype wire

/* src/chtab_back.sv */
// chtab_back: executes queued requests on the bucket heads and node pool
// depends on chtab_pkg and chtab_ram
`default_nettype none
module chtab_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_empty,
  input  wire chtab_pkg::req_t              q_head,
  output logic                              q_pop,
  input  wire logic [chtab_pkg::PTR_W-1:0]  table_size,
  input  wire logic [chtab_pkg::DATA_W-1:0] not_found_value,
  input  wire logic                         cfg_clear,
  output logic                              out_valid,
  output logic [chtab_pkg::DATA_W-1:0]      out_result_value,
  output chtab_pkg::status_t                out_status
);
  import chtab_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HEAD = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_FREE = 2'd3;

  logic [1:0]          st_r, st_nxt;
  opcode_t             op_r, op_nxt;
  logic [DATA_W-1:0]   key_r, key_nxt, val_r, val_nxt, res_r, res_nxt;
  logic [IDX_W-1:0]    bkt_r, bkt_nxt;
  logic [PTR_W-1:0]    cur_r, cur_nxt, prev_r, prev_nxt;
  logic [PTR_W-1:0]    free_top_r, free_top_nxt;
  logic [PTR_W-1:0]    fresh_used_r, fresh_used_nxt;
  logic [PTR_W-1:0]    count_r, count_nxt;
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic                ov_nxt;
  logic [DATA_W-1:0]   ores_nxt;
  status_t             ost_nxt;

  logic                  bh_we, kv_we, nx_we;
  logic [IDX_W-1:0]      bh_waddr, bh_raddr, kv_waddr, kv_raddr, nx_waddr, nx_raddr;
  logic [PTR_W-1:0]      bh_wdata, bh_rdata, nx_wdata, nx_rdata;
  logic [2*DATA_W-1:0]   kv_wdata, kv_rdata;
  logic [PTR_W-1:0]      head, fresh_node;

  chtab_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_bucket_ram (
    .clk(clk), .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata),
    .raddr(bh_raddr), .rdata(bh_rdata)
  );

  chtab_ram #(.WIDTH(2*DATA_W), .DEPTH(CAPACITY)) u_kv_ram (
    .clk(clk), .we(kv_we), .waddr(kv_waddr), .wdata(kv_wdata),
    .raddr(kv_raddr), .rdata(kv_rdata)
  );

  chtab_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata)
  );

  // a bucket never written since the last clear reads as empty
  assign head       = valid_r[bkt_r] ? bh_rdata : NIL;
  // untouched nodes are handed out from the top of the pool downward
  assign fresh_node = table_size - PTR_W'(1) - fresh_used_r;

  always_comb begin
    st_nxt         = st_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    res_nxt        = res_r;
    bkt_nxt        = bkt_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    free_top_nxt   = free_top_r;
    fresh_used_nxt = fresh_used_r;
    count_nxt      = count_r;
    valid_nxt      = valid_r;
    ov_nxt         = 1'b0;
    ores_nxt       = not_found_value;
    ost_nxt        = ST_OK;
    q_pop          = 1'b0;
    bh_we    = 1'b0;
    bh_waddr = bkt_r;
    bh_wdata = '0;
    bh_raddr = q_head.bucket;
    kv_we    = 1'b0;
    kv_waddr = '0;
    kv_wdata = {key_r, val_r};
    kv_raddr = '0;
    nx_we    = 1'b0;
    nx_waddr = '0;
    nx_wdata = '0;
    nx_raddr = free_top_r[IDX_W-1:0];

    unique case (st_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          op_nxt  = q_head.op;
          key_nxt = q_head.key;
          val_nxt = q_head.value;
          bkt_nxt = q_head.bucket;
          if (q_head.op == OP_CLEAR) begin
            valid_nxt      = '0;
            free_top_nxt   = NIL;
            fresh_used_nxt = '0;
            count_nxt      = '0;
            ov_nxt         = 1'b1;
          end else if (q_head.op == OP_ADD && count_r >= table_size) begin
            ov_nxt  = 1'b1;
            ost_nxt = ST_FULL;
          end else begin
            st_nxt = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        if (op_r == OP_ADD) begin
          if (free_top_r != NIL) begin
            cur_nxt      = free_top_r;
            free_top_nxt = nx_rdata;
          end else begin
            cur_nxt        = fresh_node;
            fresh_used_nxt = fresh_used_r + 1'b1;
          end
          kv_we    = 1'b1;
          kv_waddr = cur_nxt[IDX_W-1:0];
          nx_we    = 1'b1;
          nx_waddr = cur_nxt[IDX_W-1:0];
          nx_wdata = head;
          bh_we    = 1'b1;
          bh_wdata = cur_nxt;
          valid_nxt[bkt_r] = 1'b1;
          count_nxt = count_r + 1'b1;
          ov_nxt    = 1'b1;
          st_nxt    = S_IDLE;
        end else if (head == NIL) begin
          ov_nxt  = 1'b1;
          ost_nxt = ST_ABSENT;
          st_nxt  = S_IDLE;
        end else begin
          cur_nxt  = head;
          prev_nxt = NIL;
          kv_raddr = head[IDX_W-1:0];
          nx_raddr = head[IDX_W-1:0];
          st_nxt   = S_WALK;
        end
      end
      S_WALK: begin
        if (kv_rdata[2*DATA_W-1:DATA_W] == key_r) begin
          res_nxt = kv_rdata[DATA_W-1:0];
          if (op_r == OP_DELETE) begin
            // unlink here, push onto the free list next cycle
            if (prev_r == NIL) begin
              bh_we    = 1'b1;
              bh_wdata = nx_rdata;
            end else begin
              nx_we    = 1'b1;
              nx_waddr = prev_r[IDX_W-1:0];
              nx_wdata = nx_rdata;
            end
            st_nxt = S_FREE;
          end else begin
            ov_nxt   = 1'b1;
            ores_nxt = kv_rdata[DATA_W-1:0];
            st_nxt   = S_IDLE;
          end
        end else if (nx_rdata == NIL) begin
          ov_nxt  = 1'b1;
          ost_nxt = ST_ABSENT;
          st_nxt  = S_IDLE;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = nx_rdata;
          kv_raddr = nx_rdata[IDX_W-1:0];
          nx_raddr = nx_rdata[IDX_W-1:0];
        end
      end
      S_FREE: begin
        nx_we        = 1'b1;
        nx_waddr     = cur_r[IDX_W-1:0];
        nx_wdata     = free_top_r;
        free_top_nxt = cur_r;
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
        end
        ov_nxt   = 1'b1;
        ores_nxt = res_r;
        st_nxt   = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase

    if (cfg_clear) begin
      valid_nxt      = '0;
      free_top_nxt   = NIL;
      fresh_used_nxt = '0;
      count_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      free_top_r   <= NIL;
      fresh_used_r <= '0;
      count_r      <= '0;
      valid_r      <= '0;
      out_valid    <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      free_top_r   <= free_top_nxt;
      fresh_used_r <= fresh_used_nxt;
      count_r      <= count_nxt;
      valid_r      <= valid_nxt;
      out_valid    <= ov_nxt;
    end
    op_r             <= op_nxt;
    key_r            <= key_nxt;
    val_r            <= val_nxt;
    res_r            <= res_nxt;
    bkt_r            <= bkt_nxt;
    cur_r            <= cur_nxt;
    prev_r           <= prev_nxt;
    out_result_value <= ores_nxt;
    out_status       <= ost_nxt;
  end

endmodule
`default_nettype wire

/* src/chained_hash_table_top.sv */
// chained_hash_table_top: hash front, two-word queue and table back.
// a word goes through hash and modulo in the front, the queue, then the bucket head read in
// the back, plus the chain walk node by node and a free-list step on a delete hit; a clear
// skips the hash and modulo, and a refused add or a clear ends at the queue head. the front
// takes a new word only when the last is pushed, the back runs alongside; results cannot be stalled.
// reset: synchronous, active low; table empty, table_size 256, not-found 0.
`default_nettype none
module chained_hash_table_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire chtab_pkg::opcode_t           in_opcode,
  input  wire logic [chtab_pkg::DATA_W-1:0] in_key,
  input  wire logic [chtab_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  output logic [chtab_pkg::DATA_W-1:0]      out_result_value,
  output chtab_pkg::status_t                out_status,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [chtab_pkg::DATA_W-1:0] cfg_wdata
);
  import chtab_pkg::*;

  logic [PTR_W-1:0]  table_size_r, table_size_nxt;
  logic [DATA_W-1:0] not_found_r, not_found_nxt;
  logic [TS_W-1:0]   ts_raw;
  logic              cfg_clear, push, q_full, q_empty, q_pop;
  req_t              push_data, q_head;

  assign ts_raw    = cfg_wdata[TS_W-1:0];
  assign cfg_clear = cfg_we && (cfg_index == CFG_TABLE_SIZE);

  always_comb begin
    table_size_nxt = table_size_r;
    not_found_nxt  = not_found_r;
    if (cfg_we) begin
      if (cfg_index == CFG_TABLE_SIZE) begin
        // out-of-range sizes are clamped into one..capacity
        if (ts_raw == '0) begin
          table_size_nxt = PTR_W'(1);
        end else if (32'(ts_raw) > 32'(CAPACITY)) begin
          table_size_nxt = PTR_W'(CAPACITY);
        end else begin
          table_size_nxt = PTR_W'(ts_raw);
        end
      end else begin
        not_found_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= PTR_W'(CAPACITY);
      not_found_r  <= '0;
    end else begin
      table_size_r <= table_size_nxt;
      not_found_r  <= not_found_nxt;
    end
  end

  chtab_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_key(in_key), .in_value(in_value),
    .table_size(table_size_r), .push(push), .push_data(push_data),
    .q_full(q_full)
  );

  chtab_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .full(q_full), .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  chtab_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_head(q_head),
    .q_pop(q_pop), .table_size(table_size_r), .not_found_value(not_found_r),
    .cfg_clear(cfg_clear), .out_valid(out_valid),
    .out_result_value(out_result_value), .out_status(out_status)
  );

endmodule
`default_nettype wire

/* bench/testbench.sv */
// testbench: self-checking bench for chained_hash_table_top, with directed and random requests
// predicts each response with a local chained table model; depends on chtab_pkg and the rtl
`default_nettype none
module testbench;
  import chtab_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 40;

  typedef struct {
    logic [31:0] value;
    status_t     status;
  } resp_t;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           start;
  logic           busy;
  opcode_t        in_opcode;
  logic [31:0]    in_key;
  logic [31:0]    in_value;
  logic           out_valid;
  logic [31:0]    out_result_value;
  status_t        out_status;
  logic           cfg_we;
  logic           cfg_index;
  logic [31:0]    cfg_wdata;

  // local copy of the table
  int unsigned    tbl_size;
  logic [31:0]    miss_value;
  int unsigned    head_of[CAPACITY];
  logic [31:0]    key_of[CAPACITY];
  logic [31:0]    val_of[CAPACITY];
  int unsigned    next_of[CAPACITY];
  int unsigned    free_ptr;
  int unsigned    n_entries;

  resp_t          pending_resp[$];
  int             n_errors = 0;
  int             idle_cycles = 0;
  logic [31:0]    key_pool[16];

  chained_hash_table_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_key(in_key), .in_value(in_value),
    .out_valid(out_valid), .out_result_value(out_result_value),
    .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] mix32(logic [31:0] h);
    h = h ^ (h >> 16);
    h = h * 32'h85eb_ca6b;
    h = h ^ (h >> 13);
    h = h * 32'hc2b2_ae35;
    h = h ^ (h >> 16);
    return h;
  endfunction

  task automatic empty_table();
    n_entries = 0;
    free_ptr = CAPACITY;
    for (int i = 0; i < CAPACITY; i++) begin
      head_of[i] = CAPACITY;
      next_of[i] = CAPACITY;
    end
    for (int i = 0; i < tbl_size; i++) begin
      next_of[i] = free_ptr;
      free_ptr = i;
    end
  endtask

  task automatic predict_response(opcode_t op, logic [31:0] k, logic [31:0] v);
    resp_t r;
    int unsigned b, n, prev;
    r.value = miss_value;
    r.status = ST_OK;
    if (op == OP_CLEAR) begin
      empty_table();
    end else if (op == OP_ADD) begin
      if (n_entries >= tbl_size || free_ptr >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        b = mix32(k) % tbl_size;
        n = free_ptr;
        free_ptr = next_of[n];
        next_of[n] = head_of[b];
        key_of[n] = k;
        val_of[n] = v;
        head_of[b] = n;
        n_entries++;
      end
    end else begin
      b = mix32(k) % tbl_size;
      prev = CAPACITY;
      n = head_of[b];
      r.status = ST_ABSENT;
      for (int s = 0; n < CAPACITY && s < CAPACITY; s++) begin
        if (key_of[n] == k) begin
          r.value = val_of[n];
          r.status = ST_OK;
          if (op == OP_DELETE) begin
            if (prev < CAPACITY) next_of[prev] = next_of[n];
            else head_of[b] = next_of[n];
            next_of[n] = free_ptr;
            free_ptr = n;
            if (n_entries > 0) n_entries--;
          end
          break;
        end
        prev = n;
        n = next_of[n];
      end
    end
    pending_resp.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    n_errors++;
  endtask

  // result words cannot be held off, so every strobe is checked right away
  always @(posedge clk) begin
    resp_t r;
    if (rst_n && out_valid) begin
      if (pending_resp.size() == 0) begin
        report_mismatch("unexpected word", out_result_value, 32'h0);
      end else begin
        r = pending_resp.pop_front();
        if (out_result_value !== r.value)
          report_mismatch("result_value", out_result_value, r.value);
        if (out_status !== r.status)
          report_mismatch("status", 32'(out_status), 32'(r.status));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // start is left high; the caller lowers it before a gap
  task automatic send_word(opcode_t op, logic [31:0] k, logic [31:0] v);
    start <= 1'b1;
    in_opcode <= op;
    in_key <= k;
    in_value <= v;
    do @(posedge clk); while (busy);
    predict_response(op, k, v);
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TABLE_SIZE) begin
      tbl_size = data[8:0];
      if (tbl_size < 1) tbl_size = 1;
      if (tbl_size > CAPACITY) tbl_size = CAPACITY;
      empty_table();
    end else begin
      miss_value = data;
    end
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_word(OP_FIND, 32'h0, 32'h0);
    send_word(OP_DELETE, 32'hffff_ffff, 32'hffff_ffff);
    send_word(OP_ADD, 32'hffff_ffff, 32'hffff_ffff);
    send_word(OP_ADD, 32'h0, 32'h0);
    send_word(OP_FIND, 32'hffff_ffff, 32'h0);
    send_word(OP_FIND, 32'h0, 32'hffff_ffff);
    send_word(OP_CLEAR, 32'h1234_5678, 32'h9abc_def0);
    send_word(OP_FIND, 32'hffff_ffff, 32'h0);
  endtask

  task automatic test_small_table();
    write_reg(CFG_NOT_FOUND, 32'hdead_beef);
    write_reg(CFG_TABLE_SIZE, 32'h0);        // zero clamps to one
    send_word(OP_ADD, 32'h11, 32'ha);
    send_word(OP_ADD, 32'h22, 32'hb);        // full
    send_word(OP_FIND, 32'h11, 32'h0);
    write_reg(CFG_TABLE_SIZE, 32'hffff_fe03); // upper bits dropped, size 3
    send_word(OP_ADD, 32'h5, 32'h1);
    send_word(OP_ADD, 32'h5, 32'h2);          // duplicate, newest wins
    send_word(OP_ADD, 32'h7, 32'h3);
    send_word(OP_ADD, 32'h9, 32'h4);          // full
    send_word(OP_FIND, 32'h5, 32'h0);
    send_word(OP_DELETE, 32'h5, 32'h0);
    send_word(OP_FIND, 32'h5, 32'h0);
    send_word(OP_DELETE, 32'h5, 32'h0);
    send_word(OP_DELETE, 32'h5, 32'h0);       // miss
    send_word(OP_ADD, 32'h9, 32'h4);
    send_word(OP_CLEAR, 32'h0, 32'h0);
    send_word(OP_FIND, 32'h7, 32'h0);
    write_reg(CFG_TABLE_SIZE, 32'h101);      // above capacity clamps
    write_reg(CFG_NOT_FOUND, 32'hffff_ffff);
    write_reg(CFG_TABLE_SIZE, 32'h1ff);
  endtask

  task automatic test_random(int n_words, logic [31:0] size);
    int unsigned burst, pick;
    logic [31:0] k;
    opcode_t op;
    write_reg(CFG_TABLE_SIZE, size);
    write_reg(CFG_NOT_FOUND, $urandom);
    foreach (key_pool[i]) key_pool[i] = $urandom;
    burst = $urandom_range(1, 20);
    for (int i = 0; i < n_words; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) op = OP_ADD;
      else if (pick < 70) op = OP_FIND;
      else if (pick < 97) op = OP_DELETE;
      else op = OP_CLEAR;
      k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 15)];
      send_word(op, k, $urandom);
      if (--burst == 0) begin
        pause_sender($urandom_range(1, 30));
        burst = $urandom_range(1, 20);
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_opcode <= OP_FIND;
    in_key <= '0;
    in_value <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_TABLE_SIZE;
    cfg_wdata <= '0;
    tbl_size = CAPACITY;
    miss_value = '0;
    empty_table();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_small_table();
    test_random(200, 32'd8);
    test_random(250, 32'd256);
    test_random(150, 32'd1);
    test_random(200, $urandom_range(2, 255));
    test_random(100, 32'd3);
    wait_drained();
    if (n_errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

/* chained_hash_table_top.f */
src/chtab_pkg.sv
src/chtab_ram.sv
src/chtab_fifo.sv
src/chtab_front.sv
src/chtab_back.sv
src/chained_hash_table_top.sv
bench/testbench.sv
